// ===== hdl/gdfo_pkg.sv =====
// ----------------------------------------------------------------------------
// gdfo_pkg - shared types and constants
// Item layouts, status and action codes, parameter defaults for the
// depth-first order block.
// ----------------------------------------------------------------------------
package gdfo_pkg;

    localparam int MAX_NODES_DEF  = 64;
    localparam int MAX_DEGREE_DEF = 8;

    localparam int NODE_W   = 6;    // node id width on the ports
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 7;

    localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 7'd64;

    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_RUN = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic              action;
        logic [NODE_W-1:0] edge_from;
        logic [NODE_W-1:0] edge_to;
        logic              edge_directed;
    } t_in_item;

    typedef struct packed {
        logic [NODE_W-1:0]   visit_node;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_out_item;

endpackage

// ===== hdl/graph_depth_first_order.sv =====
// ----------------------------------------------------------------------------
// graph_depth_first_order - depth-first walk over stored neighbor lists
// Add-edge items append to per-node lists or are refused, each with one status result;
// a run item walks from node 0 and emits the reached nodes in visit order, last one flagged.
// ----------------------------------------------------------------------------
// Add edge: reads the counts of from and to, checks them, stores from -> to and, if undirected,
//   to -> from, then gives its result; a dropped edge goes from the checks to its result. Run: a sweep
//   clears the visited marks, then neighbor slots are scanned and frames popped; output stalls hold the walk.
// One item at a time: o_in_ready is high only in idle, after the previous result.
// Reset: synchronous, active low; then a pass over all MAX_NODES entries clears the
//   neighbor counts before the first item is taken.
module graph_depth_first_order #(
    parameter int MAX_NODES  = gdfo_pkg::MAX_NODES_DEF,
    parameter int MAX_DEGREE = gdfo_pkg::MAX_DEGREE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  gdfo_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output gdfo_pkg::t_out_item            o_out_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gdfo_pkg::CFG_W-1:0]     i_cfg_data
);

    // widths
    localparam int NW  = $clog2(MAX_NODES);                  // node id
    localparam int CW  = (NW + 1 > 7) ? NW + 1 : 7;          // alu / live count
    localparam int DW  = $clog2(MAX_DEGREE + 1);             // list count
    localparam int SW  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int FW  = gdfo_pkg::NODE_W;
    localparam int NBR_DEPTH = MAX_NODES << SW;

    // sequencer states
    localparam logic [3:0] S_INIT      = 4'd0;   // clear neighbor counts
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_ADD_A     = 4'd2;   // read count of from
    localparam logic [3:0] S_ADD_B     = 4'd3;   // read count of to
    localparam logic [3:0] S_ADD_C     = 4'd4;   // checks
    localparam logic [3:0] S_ADD_W1    = 4'd5;   // store from -> to
    localparam logic [3:0] S_ADD_W2    = 4'd6;   // store to -> from
    localparam logic [3:0] S_ACK       = 4'd7;
    localparam logic [3:0] S_RUN_CLR   = 4'd8;   // clear visited marks
    localparam logic [3:0] S_RUN_START = 4'd9;
    localparam logic [3:0] S_LOAD_CNT  = 4'd10;  // count of top node ready
    localparam logic [3:0] S_SCAN      = 4'd11;  // next slot or pop
    localparam logic [3:0] S_NB        = 4'd12;  // neighbor id ready
    localparam logic [3:0] S_VIS       = 4'd13;  // visited mark ready
    localparam logic [3:0] S_POP       = 4'd14;  // parent frame ready
    localparam logic [3:0] S_FINISH    = 4'd15;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    logic [3:0]    r_state, n_state;
    logic [NW-1:0] r_idx, n_idx;          // sweep index
    logic [CW-1:0] r_live, n_live;        // effective node count
    logic [NW-1:0] r_from, n_from;
    logic [NW-1:0] r_to, n_to;
    logic          r_dir, n_dir;
    logic          r_bad, n_bad;          // an id at or above the live count
    logic [DW-1:0] r_cnt_a, n_cnt_a;      // list length of from
    logic [DW-1:0] r_cnt_b, n_cnt_b;      // slot to use in the list of to
    logic [gdfo_pkg::STATUS_W-1:0] r_status, n_status;

    // top frame of the walk is held here; lower frames live in the stack
    logic [NW-1:0] r_cur, n_cur;
    logic [DW-1:0] r_slot, n_slot;
    logic [DW-1:0] r_cnt, n_cnt;
    logic [NW:0]   r_depth, n_depth;      // frames including the top
    logic [NW-1:0] r_nb, n_nb;
    logic [NW-1:0] r_pend, n_pend;        // reached node not yet emitted

    // memories and their registered read data
    logic [NW-1:0]    r_nbr_mem [0:NBR_DEPTH-1];
    logic [DW-1:0]    r_cnt_mem [0:MAX_NODES-1];
    logic             r_vis_mem [0:MAX_NODES-1];
    logic [NW+DW-1:0] r_stk_mem [0:MAX_NODES-1];
    logic [NW-1:0]    r_nbr_q;
    logic [DW-1:0]    r_cnt_q;
    logic             r_vis_q;
    logic [NW+DW-1:0] r_stk_q;

    // memory controls
    logic             w_nbr_we;
    logic [NW+SW-1:0] w_nbr_waddr, w_nbr_raddr;
    logic [NW-1:0]    w_nbr_wdata;
    logic             w_cnt_we;
    logic [NW-1:0]    w_cnt_waddr, w_cnt_raddr;
    logic [DW-1:0]    w_cnt_wdata;
    logic             w_vis_we;
    logic [NW-1:0]    w_vis_waddr, w_vis_raddr;
    logic             w_vis_wdata;
    logic             w_stk_we;
    logic [NW-1:0]    w_stk_waddr, w_stk_raddr;
    logic [NW+DW-1:0] w_stk_wdata;

    // shared unit and output register
    logic [CW-1:0]       w_alu_a, w_alu_b, w_alu_sum;
    logic                w_alu_lt;
    logic                w_push, w_can_push;
    gdfo_pkg::t_out_item w_push_item;

    logic w_in_acc;
    logic w_full_a, w_full_b, w_full_self;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;

    // list room checks, against the counts read for from and to
    assign w_full_a    = (r_cnt_a >= DW'(MAX_DEGREE));
    assign w_full_b    = (r_cnt_q >= DW'(MAX_DEGREE));
    assign w_full_self = ((DW + 1)'(r_cnt_a) + (DW + 1)'(2) > (DW + 1)'(MAX_DEGREE));

    gdfo_alu #(
        .W (CW)
    ) u_alu (
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .o_sum (w_alu_sum),
        .o_lt  (w_alu_lt)
    );

    gdfo_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_item     (w_push_item),
        .o_can_push (w_can_push),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_item     (o_out_item)
    );

    // node count as used: 0 acts as 1, anything above MAX_NODES saturates
    always_comb begin
        n_live = r_live;
        if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_data == '0) begin
                n_live = CW'(1);
            end else if (CW'(i_cfg_data) > CW'(MAX_NODES)) begin
                n_live = CW'(MAX_NODES);
            end else begin
                n_live = CW'(i_cfg_data);
            end
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_from   = r_from;
        n_to     = r_to;
        n_dir    = r_dir;
        n_bad    = r_bad;
        n_cnt_a  = r_cnt_a;
        n_cnt_b  = r_cnt_b;
        n_status = r_status;
        n_cur    = r_cur;
        n_slot   = r_slot;
        n_cnt    = r_cnt;
        n_depth  = r_depth;
        n_nb     = r_nb;
        n_pend   = r_pend;

        w_nbr_we    = 1'b0;
        w_nbr_waddr = {r_from, r_cnt_a[SW-1:0]};
        w_nbr_wdata = r_to;
        w_nbr_raddr = {r_cur, r_slot[SW-1:0]};
        w_cnt_we    = 1'b0;
        w_cnt_waddr = r_from;
        w_cnt_wdata = r_cnt_a + DW'(1);
        w_cnt_raddr = r_cur;
        w_vis_we    = 1'b0;
        w_vis_waddr = r_idx;
        w_vis_wdata = 1'b0;
        w_vis_raddr = r_nb;
        w_stk_we    = 1'b0;
        w_stk_waddr = r_depth[NW-1:0] - NW'(1);
        w_stk_wdata = {r_cur, r_slot};
        w_stk_raddr = r_depth[NW-1:0] - NW'(2);

        w_alu_a = CW'(r_idx);
        w_alu_b = CW'(1);

        w_push      = 1'b0;
        w_push_item = '{visit_node: FW'(r_pend), status: gdfo_pkg::ST_OK, last: 1'b0};

        case (r_state)
            S_INIT: begin
                w_cnt_we    = 1'b1;
                w_cnt_waddr = r_idx;
                w_cnt_wdata = '0;
                n_idx       = w_alu_sum[NW-1:0];
                if (r_idx == NW'(MAX_NODES - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    n_from   = NW'(i_in_item.edge_from);
                    n_to     = NW'(i_in_item.edge_to);
                    n_dir    = i_in_item.edge_directed;
                    n_bad    = (CW'(i_in_item.edge_from) >= r_live) ||
                               (CW'(i_in_item.edge_to) >= r_live);
                    n_status = gdfo_pkg::ST_OK;
                    n_idx    = '0;
                    if (i_in_item.action == gdfo_pkg::ACT_RUN) begin
                        n_state = S_RUN_CLR;
                    end else begin
                        n_state = S_ADD_A;
                    end
                end
            end
            S_ADD_A: begin
                w_cnt_raddr = r_from;
                n_state     = S_ADD_B;
            end
            S_ADD_B: begin
                w_cnt_raddr = r_to;
                n_cnt_a     = r_cnt_q;
                n_state     = S_ADD_C;
            end
            S_ADD_C: begin
                n_state = S_ADD_W1;
                if (r_bad) begin
                    n_status = gdfo_pkg::ST_RANGE;
                    n_state  = S_ACK;
                end else if (r_dir) begin
                    if (w_full_a) begin
                        n_status = gdfo_pkg::ST_FULL;
                        n_state  = S_ACK;
                    end
                end else if (r_from == r_to) begin
                    // undirected self loop takes two slots of one list
                    n_cnt_b = r_cnt_a + DW'(1);
                    if (w_full_self) begin
                        n_status = gdfo_pkg::ST_FULL;
                        n_state  = S_ACK;
                    end
                end else begin
                    n_cnt_b = r_cnt_q;
                    if (w_full_a || w_full_b) begin
                        n_status = gdfo_pkg::ST_FULL;
                        n_state  = S_ACK;
                    end
                end
            end
            S_ADD_W1: begin
                w_nbr_we = 1'b1;
                w_cnt_we = 1'b1;
                n_state  = r_dir ? S_ACK : S_ADD_W2;
            end
            S_ADD_W2: begin
                w_nbr_we    = 1'b1;
                w_nbr_waddr = {r_to, r_cnt_b[SW-1:0]};
                w_nbr_wdata = r_from;
                w_cnt_we    = 1'b1;
                w_cnt_waddr = r_to;
                w_cnt_wdata = r_cnt_b + DW'(1);
                n_state     = S_ACK;
            end
            S_ACK: begin
                w_push_item = '{visit_node: '0, status: r_status, last: 1'b1};
                if (w_can_push) begin
                    w_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RUN_CLR: begin
                // node 0 is marked during the sweep itself
                w_vis_we    = 1'b1;
                w_vis_wdata = (r_idx == '0);
                n_idx       = w_alu_sum[NW-1:0];
                if (r_idx == NW'(MAX_NODES - 1)) begin
                    n_idx   = '0;
                    n_state = S_RUN_START;
                end
            end
            S_RUN_START: begin
                n_cur       = '0;
                n_slot      = '0;
                n_depth     = (NW + 1)'(1);
                n_pend      = '0;
                w_cnt_raddr = '0;
                n_state     = S_LOAD_CNT;
            end
            S_LOAD_CNT: begin
                n_cnt   = r_cnt_q;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                w_alu_a = CW'(r_slot);
                w_alu_b = CW'(r_cnt);
                if (w_alu_lt) begin
                    n_state = S_NB;
                end else if (r_depth == (NW + 1)'(1)) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_POP;
                end
            end
            S_NB: begin
                n_nb        = r_nbr_q;
                w_vis_raddr = r_nbr_q;
                n_slot      = r_slot + DW'(1);
                n_state     = S_VIS;
            end
            S_VIS: begin
                // stale ids at or above the live count are skipped
                w_alu_a = CW'(r_nb);
                w_alu_b = r_live;
                if (w_alu_lt && !r_vis_q && (r_depth < (NW + 1)'(MAX_NODES))) begin
                    if (w_can_push) begin
                        w_push      = 1'b1;
                        n_pend      = r_nb;
                        w_vis_we    = 1'b1;
                        w_vis_waddr = r_nb;
                        w_vis_wdata = 1'b1;
                        w_stk_we    = 1'b1;
                        n_cur       = r_nb;
                        n_slot      = '0;
                        n_depth     = r_depth + (NW + 1)'(1);
                        w_cnt_raddr = r_nb;
                        n_state     = S_LOAD_CNT;
                    end
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_POP: begin
                n_cur       = r_stk_q[NW+DW-1:DW];
                n_slot      = r_stk_q[DW-1:0];
                n_depth     = r_depth - (NW + 1)'(1);
                w_cnt_raddr = r_stk_q[NW+DW-1:DW];
                n_state     = S_LOAD_CNT;
            end
            S_FINISH: begin
                w_push_item.last = 1'b1;
                if (w_can_push) begin
                    w_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_idx   <= '0;
            r_live  <= (CW'(gdfo_pkg::NODE_COUNT_RESET) > CW'(MAX_NODES)) ?
                       CW'(MAX_NODES) : CW'(gdfo_pkg::NODE_COUNT_RESET);
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_live  <= n_live;
        end
    end

    always_ff @(posedge i_clk) begin
        r_from   <= n_from;
        r_to     <= n_to;
        r_dir    <= n_dir;
        r_bad    <= n_bad;
        r_cnt_a  <= n_cnt_a;
        r_cnt_b  <= n_cnt_b;
        r_status <= n_status;
        r_cur    <= n_cur;
        r_slot   <= n_slot;
        r_cnt    <= n_cnt;
        r_depth  <= n_depth;
        r_nb     <= n_nb;
        r_pend   <= n_pend;
    end

    // ------------------------------------------------------------------
    // memories: one write and one registered read each
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_nbr_we) begin
            r_nbr_mem[w_nbr_waddr] <= w_nbr_wdata;
        end
        r_nbr_q <= r_nbr_mem[w_nbr_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_cnt_we) begin
            r_cnt_mem[w_cnt_waddr] <= w_cnt_wdata;
        end
        r_cnt_q <= r_cnt_mem[w_cnt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_vis_we) begin
            r_vis_mem[w_vis_waddr] <= w_vis_wdata;
        end
        r_vis_q <= r_vis_mem[w_vis_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_stk_we) begin
            r_stk_mem[w_stk_waddr] <= w_stk_wdata;
        end
        r_stk_q <= r_stk_mem[w_stk_raddr];
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_can_push)
        else $error("result pushed into a full output register");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("second item taken while one is in work");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status != gdfo_pkg::ST_OK)) |-> o_out_item.last)
        else $error("error status on a result that is not last");

    a_stack_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ((r_depth != '0) && (r_depth <= (NW + 1)'(MAX_NODES))))
        else $error("walk stack depth out of bounds");

endmodule

// ===== hdl/gdfo_alu.sv =====
// ----------------------------------------------------------------------------
// gdfo_alu - shared add and compare unit
// One adder and one magnitude compare, time shared by the sequencer.
// ----------------------------------------------------------------------------
module gdfo_alu #(
    parameter int W = 8
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic [W-1:0] o_sum,
    output logic         o_lt
);

    assign o_sum = i_a + i_b;
    assign o_lt  = (i_a < i_b);

endmodule

// ===== hdl/gdfo_obuf.sv =====
// ----------------------------------------------------------------------------
// gdfo_obuf - output item register
// Holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module gdfo_obuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  gdfo_pkg::t_out_item  i_item,
    output logic                 o_can_push,
    output logic                 o_valid,
    input  logic                 i_ready,
    output gdfo_pkg::t_out_item  o_item
);

    logic                r_valid;
    gdfo_pkg::t_out_item r_item;

    assign o_can_push = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push && o_can_push) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && o_can_push) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== tb/sv/tb_graph_depth_first_order.sv =====
// ----------------------------------------------------------------------------
// tb_graph_depth_first_order - self-checking bench for the depth-first walker
// Loads neighbor lists through add-edge items and starts walks from node 0.
// A directed table covers the corner cases, then random graphs are built
// over several node_count settings. Every result is checked against an
// in-bench predictor of the list store and the stack-based walk, or against a hand-typed result.
// ----------------------------------------------------------------------------
module tb_graph_depth_first_order;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES           = gdfo_pkg::MAX_NODES_DEF;
    localparam int DEGREE          = gdfo_pkg::MAX_DEGREE_DEF;
    localparam int NODE_W          = gdfo_pkg::NODE_W;
    localparam int STATUS_W        = gdfo_pkg::STATUS_W;
    localparam int CFG_W           = gdfo_pkg::CFG_W;
    localparam int CLK_HALF        = 1;
    localparam int RESET_CYCLES    = 12;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 16;
    localparam int SETTLE_CYCLES   = 8;     // quiet time before a register write
    localparam int END_CYCLES      = 64;    // watch for stray results at the end
    // Slowest legal run: ~122 items, each a full walk with 64 results, each
    // result stalled as long as the receiver allows, plus sender gaps. The
    // timeout allows about five times that.
    localparam longint TIMEOUT_NS  = 3_200_000;

    // One row of the directed table: either a register write or an item,
    // optionally with its single result typed in by hand.
    typedef struct {
        bit                            is_cfg;
        logic [CFG_W-1:0]              cfg_value;
        gdfo_pkg::t_in_item            item;
        bit                            typed;
        gdfo_pkg::t_out_item           result;
    } t_row;

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    gdfo_pkg::t_in_item  i_in_item   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    gdfo_pkg::t_out_item o_out_item;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_cfg_data  = '0;

    graph_depth_first_order dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the lists, marks and register
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]  node_count_cfg = gdfo_pkg::NODE_COUNT_RESET;
    logic [NODE_W-1:0] nbr_store [NODES][DEGREE];
    int unsigned       nbr_count [NODES] = '{default: 0};
    bit                visited   [NODES] = '{default: 1'b0};

    gdfo_pkg::t_out_item derived[$];          // outputs of the item just accepted
    gdfo_pkg::t_out_item pending_outputs[$];  // outputs still owed, oldest first

    int unsigned mismatch_count  = 0;
    int unsigned results_checked = 0;
    int unsigned edges_stored    = 0;
    int unsigned edges_full      = 0;
    int unsigned edges_range     = 0;
    int unsigned walks_run       = 0;
    int unsigned longest_walk    = 0;
    int unsigned settings_used   = 0;
    int unsigned burst_left      = 0;

    // node_count of 0 behaves as 1, anything past the array as the array size
    function automatic int unsigned live_nodes();
        if (node_count_cfg == 0) return 1;
        if (node_count_cfg > NODES) return NODES;
        return int'(node_count_cfg);
    endfunction

    // Append an edge; all-or-nothing for the undirected case.
    function automatic logic [STATUS_W-1:0] store_edge(input int unsigned from_node,
                                                       input int unsigned to_node,
                                                       input logic directed);
        int unsigned n;
        n = live_nodes();
        if (from_node >= n || to_node >= n) return gdfo_pkg::ST_RANGE;
        if (directed) begin
            if (nbr_count[from_node] >= DEGREE) return gdfo_pkg::ST_FULL;
        end else if (from_node == to_node) begin
            // undirected self loop takes two slots of the same list
            if (nbr_count[from_node] + 2 > DEGREE) return gdfo_pkg::ST_FULL;
        end else if (nbr_count[from_node] >= DEGREE || nbr_count[to_node] >= DEGREE) begin
            return gdfo_pkg::ST_FULL;
        end
        nbr_store[from_node][nbr_count[from_node]] = NODE_W'(to_node);
        nbr_count[from_node]++;
        if (!directed) begin
            nbr_store[to_node][nbr_count[to_node]] = NODE_W'(from_node);
            nbr_count[to_node]++;
        end
        return gdfo_pkg::ST_OK;
    endfunction

    // Iterative DFS from node 0; fills derived with the visit order.
    function automatic void compute_visit_order();
        int unsigned         n;
        int unsigned         depth;
        int unsigned         cur;
        int unsigned         nb;
        int unsigned         emitted;
        int unsigned         frame_node [NODES];
        int unsigned         frame_slot [NODES];
        int unsigned         order [NODES];
        gdfo_pkg::t_out_item r;
        n = live_nodes();
        for (int i = 0; i < NODES; i++) visited[i] = 1'b0;
        visited[0]    = 1'b1;
        order[0]      = 0;
        emitted       = 1;
        frame_node[0] = 0;
        frame_slot[0] = 0;
        depth         = 1;
        while (depth > 0) begin
            cur = frame_node[depth-1];
            if (frame_slot[depth-1] < nbr_count[cur]) begin
                nb = int'(nbr_store[cur][frame_slot[depth-1]]);
                frame_slot[depth-1]++;
                // stale entries past a lowered node_count are skipped
                if (nb < n && !visited[nb] && depth < NODES) begin
                    visited[nb]       = 1'b1;
                    order[emitted]    = nb;
                    emitted++;
                    frame_node[depth] = nb;
                    frame_slot[depth] = 0;
                    depth++;
                end
            end else begin
                depth--;
            end
        end
        for (int k = 0; k < emitted; k++) begin
            r.visit_node = NODE_W'(order[k]);
            r.status     = gdfo_pkg::ST_OK;
            r.last       = (k == emitted - 1);
            derived.insert(derived.size(), r);
        end
        if (emitted > longest_walk) longest_walk = emitted;
    endfunction

    function automatic void derive_outputs(input gdfo_pkg::t_in_item it);
        gdfo_pkg::t_out_item r;
        derived.delete();
        if (it.action == gdfo_pkg::ACT_RUN) begin
            compute_visit_order();
            walks_run++;
        end else begin
            r.visit_node = '0;
            r.status     = store_edge(int'(it.edge_from), int'(it.edge_to),
                                      it.edge_directed);
            r.last       = 1'b1;
            derived.insert(derived.size(), r);
            case (r.status)
                gdfo_pkg::ST_OK:   edges_stored++;
                gdfo_pkg::ST_FULL: edges_full++;
                default:           edges_range++;
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // Directed table rows
    // ------------------------------------------------------------------
    function automatic t_row edge_row(input int unsigned from_node, input int unsigned to_node,
                                      input logic directed, input bit typed = 1'b0,
                                      input logic [STATUS_W-1:0] status = gdfo_pkg::ST_OK);
        t_row r;
        r                    = '{default: '0};
        r.item.action        = gdfo_pkg::ACT_ADD;
        r.item.edge_from     = NODE_W'(from_node);
        r.item.edge_to       = NODE_W'(to_node);
        r.item.edge_directed = directed;
        r.typed              = typed;
        r.result.visit_node  = '0;
        r.result.status      = status;
        r.result.last        = 1'b1;
        return r;
    endfunction

    // A typed walk row is one that can only reach node 0.
    function automatic t_row walk_row(input bit typed);
        t_row r;
        r                   = '{default: '0};
        r.item.action       = gdfo_pkg::ACT_RUN;
        r.typed             = typed;
        r.result.visit_node = '0;
        r.result.status     = gdfo_pkg::ST_OK;
        r.result.last       = 1'b1;
        return r;
    endfunction

    function automatic t_row cfg_row(input logic [CFG_W-1:0] value);
        t_row r;
        r           = '{default: '0};
        r.is_cfg    = 1'b1;
        r.cfg_value = value;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Items go out in bursts; between most bursts valid drops for a random gap.
    // Valid is only lowered when a real gap follows, so it never gets two
    // updates in one step.
    task automatic send_item(input gdfo_pkg::t_in_item it, input bit typed,
                             input gdfo_pkg::t_out_item typed_res);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 1);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(8, 1);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        // item taken at this edge: work out what the block owes for it
        derive_outputs(it);
        if (typed) begin
            pending_outputs.insert(pending_outputs.size(), typed_res);
        end else begin
            foreach (derived[k]) pending_outputs.insert(pending_outputs.size(), derived[k]);
        end
    endtask

    // Stop sending and let every owed result drain out.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register writes only happen with the block idle.
    task automatic write_node_count(input logic [CFG_W-1:0] value);
        wait_for_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        node_count_cfg = value;
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Receiver side: ready follows an 8-bit stall pattern, reloaded each
    // window. Bit 0 is always set, so every window starts with ready high.
    // All-ones windows give stretches with no backpressure.
    // ------------------------------------------------------------------
    logic [7:0] stall_pattern = 8'hFF;
    logic [2:0] stall_pos     = '0;

    always @(posedge i_clk) begin
        i_out_ready <= stall_pattern[stall_pos];
        stall_pos   <= stall_pos + 3'd1;
        if (stall_pos == 3'd7) begin
            case ($urandom_range(3))
                0, 1:    stall_pattern <= 8'hFF;
                2:       stall_pattern <= 8'($urandom) | 8'h01;
                default: stall_pattern <= 8'h81;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        gdfo_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_outputs.size() == 0) begin
                report_mismatch($sformatf("unrequested result node %0d status %0d last %0d",
                                          o_out_item.visit_node, o_out_item.status,
                                          o_out_item.last));
            end else begin
                want = pending_outputs.pop_front();
                if (o_out_item.visit_node !== want.visit_node)
                    report_mismatch($sformatf("result %0d visit_node %0d, want %0d",
                                              results_checked, o_out_item.visit_node,
                                              want.visit_node));
                if (o_out_item.status !== want.status)
                    report_mismatch($sformatf("result %0d status %0d, want %0d",
                                              results_checked, o_out_item.status,
                                              want.status));
                if (o_out_item.last !== want.last)
                    report_mismatch($sformatf("result %0d last %0d, want %0d",
                                              results_checked, o_out_item.last, want.last));
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_row                rows[$];
        logic [CFG_W-1:0]    phase_setting [RANDOM_PHASES];
        gdfo_pkg::t_in_item  it;
        gdfo_pkg::t_out_item no_result;
        int unsigned         n;

        no_result = '0;
        // extremes first: above the array, mid, a single node, random,
        // tiny, exactly full size
        phase_setting = '{7'd127, 7'd16, 7'd1, 7'd0, 7'd4, 7'd64};
        phase_setting[3] = CFG_W'($urandom_range(63, 2));

        // Directed part. Starts at the reset node_count of 64.
        rows.insert(rows.size(), walk_row(1'b1));          // empty graph: root only
        rows.insert(rows.size(), edge_row(0, 63, 1'b1));   // top node id
        rows.insert(rows.size(), edge_row(63, 0, 1'b0));
        rows.insert(rows.size(), edge_row(0, 0, 1'b0));    // undirected self loop, 2 slots
        rows.insert(rows.size(), edge_row(42, 21, 1'b0));  // alternating id bits
        rows.insert(rows.size(), edge_row(0, 21, 1'b1));
        rows.insert(rows.size(), walk_row(1'b0));
        // fills node 7's list
        repeat (4) rows.insert(rows.size(), edge_row(7, 7, 1'b0));
        rows.insert(rows.size(), edge_row(7, 7, 1'b1, 1'b1, gdfo_pkg::ST_FULL));
        repeat (3) rows.insert(rows.size(), edge_row(9, 9, 1'b0));
        // node 9 one slot short of full
        rows.insert(rows.size(), edge_row(9, 10, 1'b1));
        // self loop needs two
        rows.insert(rows.size(), edge_row(9, 9, 1'b0, 1'b1, gdfo_pkg::ST_FULL));
        // nothing lands in node 9
        rows.insert(rows.size(), edge_row(7, 9, 1'b0, 1'b1, gdfo_pkg::ST_FULL));
        // ...so this one fits
        rows.insert(rows.size(), edge_row(9, 11, 1'b1));
        rows.insert(rows.size(), edge_row(0, 7, 1'b1));
        rows.insert(rows.size(), edge_row(0, 9, 1'b1));
        rows.insert(rows.size(), walk_row(1'b0));
        rows.insert(rows.size(), cfg_row(7'd0));           // acts as one node
        rows.insert(rows.size(), edge_row(1, 0, 1'b1, 1'b1, gdfo_pkg::ST_RANGE));
        rows.insert(rows.size(), edge_row(0, 63, 1'b0, 1'b1, gdfo_pkg::ST_RANGE));
        rows.insert(rows.size(), walk_row(1'b1));          // only node 0 is live
        rows.insert(rows.size(), cfg_row(7'd10));          // stale neighbors now skipped
        rows.insert(rows.size(), walk_row(1'b0));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                write_node_count(rows[i].cfg_value);
            end else begin
                send_item(rows[i].item, rows[i].typed, rows[i].result);
            end
        end

        // Random part: each phase picks a node_count and grows the graph.
        // Lists persist across phases, so later phases hit full lists and
        // stale neighbors left over from larger settings.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_node_count(phase_setting[p]);
            n = live_nodes();
            repeat (ITEMS_PER_PHASE) begin
                it.action        = ($urandom_range(99) < 15) ? gdfo_pkg::ACT_RUN
                                                             : gdfo_pkg::ACT_ADD;
                it.edge_from     = NODE_W'($urandom);
                it.edge_to       = NODE_W'($urandom);
                it.edge_directed = 1'($urandom);
                if (it.action == gdfo_pkg::ACT_ADD) begin
                    if (n < NODES && $urandom_range(9) == 0) begin
                        // out-of-range id on one side or both
                        case ($urandom_range(2))
                            0: it.edge_from = NODE_W'($urandom_range(NODES - 1, n));
                            1: it.edge_to   = NODE_W'($urandom_range(NODES - 1, n));
                            default: begin
                                it.edge_from = NODE_W'($urandom_range(NODES - 1, n));
                                it.edge_to   = NODE_W'($urandom_range(NODES - 1, n));
                            end
                        endcase
                    end else begin
                        // bias toward the root so walks reach far
                        it.edge_from = ($urandom_range(2) == 0) ? '0
                                       : NODE_W'($urandom_range(n - 1));
                        it.edge_to   = NODE_W'($urandom_range(n - 1));
                    end
                end
                send_item(it, 1'b0, no_result);
                // occasionally hold off until the block has caught up
                if ($urandom_range(19) == 0) wait_for_results();
            end
        end

        wait_for_results();
        repeat (END_CYCLES) @(posedge i_clk);

        $display("Run covered %0d edge items (%0d stored, %0d list full, %0d out of range)",
                 edges_stored + edges_full + edges_range, edges_stored, edges_full, edges_range);
        $display("and %0d walks (longest %0d nodes); %0d results checked, %0d node_count writes.",
                 walks_run, longest_walk, results_checked, settings_used);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results outstanding", pending_outputs.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
